/* rtl/cru_pkg.sv */
`timescale 1ns / 1ps
package cru_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);

    localparam int CH_W      = 8;
    localparam int NUM_CH    = 4;
    localparam int TEXEL_W   = CH_W * NUM_CH;
    localparam int SZ_W      = 8;
    localparam int CRD_W     = 10;
    localparam int TAP_W     = 4;
    localparam int WGT_W     = 8;
    localparam int HS_W      = 18;
    localparam int S_W       = 26;
    localparam int FRAC      = 14;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W = 48;

    localparam logic [SZ_W-1:0] TILE_RESET = SZ_W'(128);

    localparam logic signed [WGT_W-1:0] EVEN_W [4] = '{
        -8'sd3, 8'sd29, 8'sd111, -8'sd9
    };

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_READ  = 1'b1
    } cru_func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_WIDTH  = 1'b0,
        REG_TILE_HEIGHT = 1'b1
    } cru_reg_t;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_GATHER  = 5'b00010,
        S_DRAIN_A = 5'b00100,
        S_DRAIN_B = 5'b01000,
        S_FINISH  = 5'b10000
    } cru_state_t;

    typedef struct packed {
        logic             load;
        logic             write;
        logic             issue;
        logic [TAP_W-1:0] tap;
        logic             finish;
    } cru_cmd_t;

    typedef struct packed {
        logic in_read;
        logic in_bad;
    } cru_sts_t;

    // odd phase uses the even weights reversed
    function automatic logic signed [WGT_W-1:0] tap_weight(input logic odd,
                                                          input logic [1:0] idx);
        logic [1:0] k;
        k = odd ? (2'd3 - idx) : idx;
        return EVEN_W[k];
    endfunction

    function automatic logic [SZ_W-1:0] eff_size(input logic [SZ_W-1:0] v, input int max);
        if (v == '0) begin
            return SZ_W'(1);
        end
        if (32'(v) > max) begin
            return SZ_W'(max);
        end
        return v;
    endfunction

    // round half away from zero, then clamp to a byte
    function automatic logic [CH_W-1:0] to_byte(input logic signed [S_W-1:0] s);
        logic signed [S_W-1:0]  t;
        logic [S_W-FRAC-1:0]    r;
        if (s <= 0) begin
            return '0;
        end
        t = s + S_W'(1 << (FRAC - 1));
        r = t[S_W-1:FRAC];
        if (r[S_W-FRAC-1:CH_W] != '0) begin
            return '1;
        end
        return r[CH_W-1:0];
    endfunction

endpackage

/* rtl/cru_ctrl.sv */
`timescale 1ns / 1ps
module cru_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  cru_pkg::cru_sts_t sts,
    output cru_pkg::cru_cmd_t cmd
);

    cru_pkg::cru_state_t           state_reg, state_next;
    logic [cru_pkg::TAP_W-1:0]     tap_reg, tap_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic                          accept;
    logic                          out_free;

    assign s_tready = (state_reg == cru_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        tap_next      = tap_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.tap       = tap_reg;
        unique case (state_reg)
            cru_pkg::S_IDLE: begin
                cmd.write = accept && !sts.in_read;
                cmd.load  = accept && sts.in_read;
                tap_next  = '0;
                if (accept && sts.in_read) begin
                    state_next = sts.in_bad ? cru_pkg::S_FINISH : cru_pkg::S_GATHER;
                end
            end
            cru_pkg::S_GATHER: begin
                cmd.issue = 1'b1;
                tap_next  = tap_reg + 1'b1;
                if (tap_reg == '1) begin
                    state_next = cru_pkg::S_DRAIN_A;
                end
            end
            cru_pkg::S_DRAIN_A: begin
                state_next = cru_pkg::S_DRAIN_B;
            end
            cru_pkg::S_DRAIN_B: begin
                state_next = cru_pkg::S_FINISH;
            end
            cru_pkg::S_FINISH: begin
                if (out_free) begin
                    cmd.finish    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = cru_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cru_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cru_pkg::S_IDLE;
            tap_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tap_reg      <= tap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

/* rtl/cru_dp.sv */
`timescale 1ns / 1ps
module cru_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [cru_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [0:0]                        s_tuser,
    input  logic                              cfg_we,
    input  logic [cru_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [cru_pkg::SZ_W-1:0]          cfg_wdata,
    input  cru_pkg::cru_cmd_t                 cmd,
    output cru_pkg::cru_sts_t                 sts,
    output logic [cru_pkg::TEXEL_W-1:0]       m_tdata,
    output logic [0:0]                        m_tuser
);

    localparam int CW  = cru_pkg::CH_W;
    localparam int NCH = cru_pkg::NUM_CH;

    // texel store, undefined until written
    logic [cru_pkg::TEXEL_W-1:0] mem [cru_pkg::DEPTH];

    logic [cru_pkg::SZ_W-1:0]  tile_w_reg, tile_h_reg;
    logic [cru_pkg::SZ_W-1:0]  w_eff, h_eff;
    logic [cru_pkg::SZ_W:0]    w_dbl, h_dbl;

    logic [CW-1:0]                   in_col, in_row;
    logic [cru_pkg::TEXEL_W-1:0]     in_texel;
    logic signed [cru_pkg::CRD_W-1:0] fx_in, fy_in;
    logic                            in_store_ok;

    logic signed [cru_pkg::CRD_W-1:0] fx_reg, fy_reg;
    logic                            odd_x_reg, odd_y_reg, bad_reg;

    logic signed [cru_pkg::CRD_W-1:0] sx, sy;
    logic [cru_pkg::ADDR_W-1:0]      waddr, raddr, addr;

    logic [cru_pkg::TEXEL_W-1:0]     rd_data_reg;
    logic                            vb_reg;
    logic [cru_pkg::TAP_W-1:0]       tap_b_reg;

    logic signed [cru_pkg::HS_W-1:0] hs_reg   [NCH];
    logic signed [cru_pkg::HS_W-1:0] hs_next  [NCH];
    logic signed [cru_pkg::S_W-1:0]  s_reg    [NCH];
    logic signed [cru_pkg::S_W-1:0]  s_next   [NCH];
    logic                            row_vld_reg;
    logic [1:0]                      row_j_reg;

    logic [cru_pkg::TEXEL_W-1:0]     out_data_reg, out_data_next;
    logic                            out_bad_reg;

    function automatic logic signed [cru_pkg::CRD_W-1:0] clamp_coord(
        input logic signed [cru_pkg::CRD_W-1:0] v,
        input logic [cru_pkg::SZ_W-1:0]         n
    );
        logic signed [cru_pkg::CRD_W-1:0] top;
        top = $signed(cru_pkg::CRD_W'(n)) - cru_pkg::CRD_W'(1);
        if (v < 0) begin
            return '0;
        end
        if (v > top) begin
            return top;
        end
        return v;
    endfunction

    // request decode
    always_comb begin
        w_eff       = cru_pkg::eff_size(tile_w_reg, cru_pkg::MAX_WIDTH);
        h_eff       = cru_pkg::eff_size(tile_h_reg, cru_pkg::MAX_HEIGHT);
        w_dbl       = {w_eff, 1'b0};
        h_dbl       = {h_eff, 1'b0};
        in_col      = s_tdata[7:0];
        in_row      = s_tdata[15:8];
        in_texel    = s_tdata[47:16];
        sts.in_read = (s_tuser[0] == cru_pkg::FUNC_READ);
        sts.in_bad  = ({1'b0, in_col} >= w_dbl) || ({1'b0, in_row} >= h_dbl);
        fx_in       = $signed(cru_pkg::CRD_W'(in_col[7:1]))
                      - (in_col[0] ? cru_pkg::CRD_W'(1) : cru_pkg::CRD_W'(2));
        fy_in       = $signed(cru_pkg::CRD_W'(in_row[7:1]))
                      - (in_row[0] ? cru_pkg::CRD_W'(1) : cru_pkg::CRD_W'(2));
        in_store_ok = (32'(in_col) < cru_pkg::MAX_WIDTH)
                      && (32'(in_row) < cru_pkg::MAX_HEIGHT);
        waddr       = cru_pkg::ADDR_W'(32'(in_row) * cru_pkg::MAX_WIDTH + 32'(in_col));
    end

    // tap address, clamped to the tile edge
    always_comb begin
        sx    = clamp_coord(fx_reg + cru_pkg::CRD_W'(cmd.tap[1:0]), w_eff);
        sy    = clamp_coord(fy_reg + cru_pkg::CRD_W'(cmd.tap[3:2]), h_eff);
        raddr = cru_pkg::ADDR_W'(32'(sy[cru_pkg::CRD_W-2:0]) * cru_pkg::MAX_WIDTH
                                 + 32'(sx[cru_pkg::CRD_W-2:0]));
        addr  = cmd.write ? waddr : raddr;
    end

    always_ff @(posedge aclk) begin
        if (cmd.write && in_store_ok) begin
            mem[addr] <= in_texel;
        end
        rd_data_reg <= mem[addr];
    end

    // horizontal then vertical accumulation
    always_comb begin
        logic signed [cru_pkg::WGT_W-1:0] wx, wy;
        logic signed [CW:0]               v;
        logic signed [cru_pkg::HS_W-1:0]  hprod;
        logic signed [cru_pkg::S_W-1:0]   sprod;
        wx = cru_pkg::tap_weight(odd_x_reg, tap_b_reg[1:0]);
        wy = cru_pkg::tap_weight(odd_y_reg, row_j_reg);
        for (int c = 0; c < NCH; c++) begin
            v     = $signed({1'b0, rd_data_reg[c*CW +: CW]});
            hprod = wx * v;
            sprod = wy * hs_reg[c];
            hs_next[c] = ((tap_b_reg[1:0] == 2'd0) ? '0 : hs_reg[c]) + hprod;
            s_next[c]  = s_reg[c] + sprod;
            out_data_next[c*CW +: CW] = bad_reg ? '0 : cru_pkg::to_byte(s_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_w_reg  <= cru_pkg::TILE_RESET;
            tile_h_reg  <= cru_pkg::TILE_RESET;
            vb_reg      <= 1'b0;
            row_vld_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cru_pkg::cru_reg_t'(cfg_addr))
                    cru_pkg::REG_TILE_WIDTH:  tile_w_reg <= cfg_wdata;
                    cru_pkg::REG_TILE_HEIGHT: tile_h_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            vb_reg      <= cmd.issue;
            row_vld_reg <= vb_reg && (tap_b_reg[1:0] == 2'd3);
        end
    end

    always_ff @(posedge aclk) begin
        tap_b_reg <= cmd.tap;
        row_j_reg <= tap_b_reg[3:2];
        if (cmd.load) begin
            fx_reg    <= fx_in;
            fy_reg    <= fy_in;
            odd_x_reg <= in_col[0];
            odd_y_reg <= in_row[0];
            bad_reg   <= sts.in_bad;
        end
        for (int c = 0; c < NCH; c++) begin
            if (vb_reg) begin
                hs_reg[c] <= hs_next[c];
            end
            if (cmd.load) begin
                s_reg[c] <= '0;
            end else if (row_vld_reg) begin
                s_reg[c] <= s_next[c];
            end
        end
        if (cmd.finish) begin
            out_data_reg <= out_data_next;
            out_bad_reg  <= bad_reg;
        end
    end

    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_bad_reg;

endmodule

/* rtl/catmull_rom_2x_texel_upscaler_top.sv */
`timescale 1ns / 1ps
// channel   direction  tdata (low bit up)                    tuser
// s_        in         col, row, red, green, blue, alpha      func (0 write, 1 read)
// m_        out        red, green, blue, alpha                bad_coordinate
// cfg_      in         index 0 tile_width, index 1 tile_height
//
// a write request leaves the input ready for the next one; a read holds the input until its result
// is loaded: 16 taps gathered through the single-port texel store, one per cycle, then the
// accumulation drains through S_DRAIN_A and S_DRAIN_B, and S_FINISH loads the output register.
// a read outside the doubled image goes straight to the output register.
// aresetn is synchronous; the texel store is not cleared.
// a full output register stalls only the end of a read; writes keep flowing.
module catmull_rom_2x_texel_upscaler_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cru_pkg::IN_DATA_W-1:0] s_tdata,   // col, row, red_in, green_in, blue_in, alpha_in
    input  logic [0:0]                    s_tuser,   // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cru_pkg::TEXEL_W-1:0]   m_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic [0:0]                    m_tuser,   // bad_coordinate
    input  logic                          cfg_we,
    input  logic [cru_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [cru_pkg::SZ_W-1:0]      cfg_wdata
);

    cru_pkg::cru_cmd_t cmd;
    cru_pkg::cru_sts_t sts;

    cru_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cru_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* rtl/cru_chk.sv */
`timescale 1ns / 1ps
module cru_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [0:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cru_pkg::TEXEL_W-1:0]   m_tdata,
    input logic [0:0]                    m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // bad coordinate carries zero channels
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("bad coordinate with non-zero channels");

    // a write request never blocks the next one
    a_write_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == cru_pkg::FUNC_WRITE) |=> s_tready)
        else $error("write request stalled the input");

    // a read request occupies the block
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == cru_pkg::FUNC_READ) |=> !s_tready)
        else $error("input open during read");

endmodule

bind catmull_rom_2x_texel_upscaler_top cru_chk u_cru_chk (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import cru_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            bad;
    } texel_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata;   // col, row, red_in, green_in, blue_in, alpha_in
    logic [0:0]           s_tuser;   // func
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TEXEL_W-1:0]   m_tdata;   // red_out, green_out, blue_out, alpha_out
    logic [0:0]           m_tuser;   // bad_coordinate
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [SZ_W-1:0]      cfg_wdata;

    logic [TEXEL_W-1:0] texel_mem [DEPTH];
    bit                 texel_written [DEPTH];
    logic [SZ_W-1:0]    width_reg;
    logic [SZ_W-1:0]    height_reg;
    texel_result_t      expected_texels [$];

    int mismatch_count = 0;
    int requests_sent  = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    catmull_rom_2x_texel_upscaler_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int active_size(logic [SZ_W-1:0] v, int limit);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > limit) begin
            return limit;
        end
        return int'(v);
    endfunction

    function automatic int filter_weight(logic odd, int k);
        if (odd) begin
            case (k)
                0: return -9;
                1: return 111;
                2: return 29;
                default: return -3;
            endcase
        end
        case (k)
            0: return -3;
            1: return 29;
            2: return 111;
            default: return -9;
        endcase
    endfunction

    // source position of tap k, clamped to the tile edge
    function automatic int tap_source(int coord, int size, int k);
        int p;
        p = coord / 2 - ((coord % 2 != 0) ? 1 : 2) + k;
        if (p < 0) begin
            return 0;
        end
        if (p > size - 1) begin
            return size - 1;
        end
        return p;
    endfunction

    // sum is in units of 1/16384; round half away from zero, clamp to a byte
    function automatic logic [CH_W-1:0] sum_to_byte(int s);
        int r;
        if (s <= 0) begin
            return '0;
        end
        r = (s + 8192) / 16384;
        if (r > 255) begin
            r = 255;
        end
        return CH_W'(r);
    endfunction

    function automatic texel_result_t upscaled_texel(logic [7:0] col, logic [7:0] row);
        texel_result_t      res;
        int                 w, h, acc, line, sx, sy, ch, i, j;
        logic [TEXEL_W-1:0] t;
        logic [CH_W-1:0]    chan [NUM_CH];
        w = active_size(width_reg, MAX_WIDTH);
        h = active_size(height_reg, MAX_HEIGHT);
        res = '0;
        if (int'(col) >= 2 * w || int'(row) >= 2 * h) begin
            res.bad = 1'b1;
            return res;
        end
        for (ch = 0; ch < NUM_CH; ch++) begin
            acc = 0;
            for (j = 0; j < 4; j++) begin
                sy = tap_source(int'(row), h, j);
                line = 0;
                for (i = 0; i < 4; i++) begin
                    sx = tap_source(int'(col), w, i);
                    t = texel_mem[sy * MAX_WIDTH + sx];
                    line += filter_weight(col[0], i) * int'(t[ch*CH_W +: CH_W]);
                end
                acc += filter_weight(row[0], j) * line;
            end
            chan[ch] = sum_to_byte(acc);
        end
        res.red   = chan[0];
        res.green = chan[1];
        res.blue  = chan[2];
        res.alpha = chan[3];
        return res;
    endfunction

    // channels lean towards the extremes so that overshoot gets clamped
    function automatic logic [TEXEL_W-1:0] random_texel();
        logic [TEXEL_W-1:0] t;
        int                 c;
        for (c = 0; c < NUM_CH; c++) begin
            case ($urandom_range(3))
                0: t[c*CH_W +: CH_W] = '0;
                1: t[c*CH_W +: CH_W] = '1;
                default: t[c*CH_W +: CH_W] = CH_W'($urandom);
            endcase
        end
        return t;
    endfunction

    function automatic logic [SZ_W-1:0] random_tile_dim();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return SZ_W'($urandom_range(6, 1));
        end
        if (r < 80) begin
            return SZ_W'($urandom_range(24, 7));
        end
        if (r < 88) begin
            return SZ_W'($urandom_range(128, 25));
        end
        if (r < 92) begin
            return '0;
        end
        if (r < 96) begin
            return SZ_W'($urandom_range(255, 129));
        end
        return SZ_W'(MAX_WIDTH);
    endfunction

    function automatic void check_field(string name, logic [CH_W-1:0] want,
                                        logic [CH_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_request(cru_func_t func, logic [7:0] col, logic [7:0] row,
                                logic [TEXEL_W-1:0] texel);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {texel, row, col};
        s_tuser  <= func;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        requests_sent++;
        if (func == FUNC_WRITE) begin
            if (int'(col) < MAX_WIDTH && int'(row) < MAX_HEIGHT) begin
                texel_mem[int'(row) * MAX_WIDTH + int'(col)] = texel;
                texel_written[int'(row) * MAX_WIDTH + int'(col)] = 1'b1;
            end
        end else begin
            expected_texels.push_back(upscaled_texel(col, row));
        end
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_texels.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_tile_size(logic [SZ_W-1:0] w, logic [SZ_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_TILE_WIDTH;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_addr  <= REG_TILE_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        width_reg  = w;
        height_reg = h;
    endtask

    // any tap not yet written gets a write first
    task automatic read_texel(logic [7:0] col, logic [7:0] row);
        int aw, ah, sx, sy, i, j;
        aw = active_size(width_reg, MAX_WIDTH);
        ah = active_size(height_reg, MAX_HEIGHT);
        if (int'(col) < 2 * aw && int'(row) < 2 * ah) begin
            for (j = 0; j < 4; j++) begin
                for (i = 0; i < 4; i++) begin
                    sx = tap_source(int'(col), aw, i);
                    sy = tap_source(int'(row), ah, j);
                    if (!texel_written[sy * MAX_WIDTH + sx]) begin
                        send_request(FUNC_WRITE, 8'(sx), 8'(sy), random_texel());
                    end
                end
            end
        end
        send_request(FUNC_READ, col, row, random_texel());
    endtask

    task automatic random_read();
        int         aw, ah;
        logic [7:0] col, row;
        aw = active_size(width_reg, MAX_WIDTH);
        ah = active_size(height_reg, MAX_HEIGHT);
        if ($urandom_range(99) < 88) begin
            col = 8'($urandom_range(2 * aw - 1));
            row = 8'($urandom_range(2 * ah - 1));
        end else begin
            col = 8'($urandom);
            row = 8'($urandom);
        end
        read_texel(col, row);
    endtask

    task automatic random_write();
        int         aw, ah, r;
        logic [7:0] col, row;
        aw = active_size(width_reg, MAX_WIDTH);
        ah = active_size(height_reg, MAX_HEIGHT);
        r = $urandom_range(99);
        if (r < 70) begin
            col = 8'($urandom_range(aw - 1));
            row = 8'($urandom_range(ah - 1));
        end else if (r < 90) begin
            col = 8'($urandom_range(MAX_WIDTH - 1));
            row = 8'($urandom_range(MAX_HEIGHT - 1));
        end else begin
            col = 8'($urandom);
            row = 8'($urandom);
        end
        send_request(FUNC_WRITE, col, row, random_texel());
    endtask

    task automatic test_directed_cases();
        send_request(FUNC_WRITE, 8'd0, 8'd0, '1);
        send_request(FUNC_WRITE, 8'd1, 8'd0, '0);
        send_request(FUNC_WRITE, 8'd0, 8'd1, '0);
        send_request(FUNC_WRITE, 8'd1, 8'd1, 32'hFF00_FF00);
        // tile size straight out of reset
        read_texel(8'd0, 8'd0);
        read_texel(8'd255, 8'd255);
        // beyond the store, dropped
        send_request(FUNC_WRITE, 8'd128, 8'd0, 32'h1234_5678);
        send_request(FUNC_WRITE, 8'd0, 8'd128, 32'h8765_4321);
        send_request(FUNC_WRITE, 8'd255, 8'd255, '1);
        wait_for_results();
        set_tile_size(8'd2, 8'd2);
        read_texel(8'd0, 8'd0);
        read_texel(8'd1, 8'd0);
        read_texel(8'd2, 8'd1);
        read_texel(8'd3, 8'd3);
        // outside the doubled image
        read_texel(8'd4, 8'd0);
        read_texel(8'd0, 8'd4);
        read_texel(8'd255, 8'd255);
        // outside the tile but inside the store, kept
        send_request(FUNC_WRITE, 8'd5, 8'd5, 32'hA5C3_3C5A);
        wait_for_results();
        set_tile_size(8'd6, 8'd6);
        read_texel(8'd11, 8'd11);
        wait_for_results();
        // zero size acts as one
        set_tile_size(8'd0, 8'd0);
        read_texel(8'd1, 8'd1);
        read_texel(8'd2, 8'd0);
    endtask

    task automatic test_tile_extremes();
        int              k, n, aw, ah;
        logic [SZ_W-1:0] w, h;
        for (k = 0; k < 7; k++) begin
            case (k)
                0: begin w = 8'd0;   h = 8'd255; end
                1: begin w = 8'd255; h = 8'd0;   end
                2: begin w = 8'd1;   h = 8'd128; end
                3: begin w = 8'd128; h = 8'd1;   end
                4: begin w = 8'd129; h = 8'd200; end
                5: begin w = 8'd128; h = 8'd128; end
                default: begin w = 8'd3; h = 8'd5; end
            endcase
            wait_for_results();
            set_tile_size(w, h);
            aw = active_size(w, MAX_WIDTH);
            ah = active_size(h, MAX_HEIGHT);
            for (n = 0; n < 12; n++) begin
                random_read();
            end
            if (2 * aw <= 255) begin
                read_texel(8'($urandom_range(255, 2 * aw)), 8'($urandom_range(2 * ah - 1)));
            end
            if (2 * ah <= 255) begin
                read_texel(8'($urandom_range(2 * aw - 1)), 8'($urandom_range(255, 2 * ah)));
            end
        end
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
        int first, seg_end;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first = requests_sent;
        while (requests_sent - first < n_items) begin
            wait_for_results();
            set_tile_size(random_tile_dim(), random_tile_dim());
            seg_end = requests_sent + $urandom_range(150, 60);
            while (requests_sent < seg_end && requests_sent - first < n_items) begin
                if ($urandom_range(99) < 55) begin
                    random_read();
                end else begin
                    random_write();
                end
            end
        end
    endtask

    // output held off long enough for the input side to back up
    task automatic test_output_stall();
        int n;
        wait_for_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_tile_size(8'd16, 8'd16);
        @(posedge aclk);
        hold_left = HOLD_CYCLES;
        @(negedge aclk);
        for (n = 0; n < 12; n++) begin
            random_read();
        end
        wait_for_results();
        for (n = 0; n < 30; n++) begin
            if (n % 3 == 0) begin
                random_write();
            end else begin
                random_read();
            end
        end
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        texel_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_texels.size() == 0) begin
                $error("result with none expected: tdata %h tuser %b", m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = expected_texels.pop_front();
                check_field("red_out",        want.red,       m_tdata[7:0]);
                check_field("green_out",      want.green,     m_tdata[15:8]);
                check_field("blue_out",       want.blue,      m_tdata[23:16]);
                check_field("alpha_out",      want.alpha,     m_tdata[31:24]);
                check_field("bad_coordinate", CH_W'(want.bad), CH_W'(m_tuser));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("** catmull_rom_2x_texel_upscaler_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = FUNC_WRITE;
        cfg_we     = 1'b0;
        cfg_addr   = REG_TILE_WIDTH;
        cfg_wdata  = '0;
        aresetn    = 1'b0;
        width_reg  = TILE_RESET;
        height_reg = TILE_RESET;
        send_idle_pct = 18;
        recv_idle_pct = 63;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_cases();
        test_tile_extremes();
        test_random_traffic(18, 63, 200);
        test_random_traffic(63, 18, 200);
        test_random_traffic(0, 0, 200);
        test_output_stall();
        wait_for_results();
        if (mismatch_count == 0) begin
            $display("** catmull_rom_2x_texel_upscaler_top: PASSED **");
        end else begin
            $display("** catmull_rom_2x_texel_upscaler_top: FAILED **");
        end
        $finish;
    end

endmodule
